@@ design/mm4x4_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4x4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4x4_pkg;

  localparam int DIM       = 4;
  localparam int CELLS     = DIM * DIM;
  localparam int IDX_W     = $clog2(DIM);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  // headroom for the sum of DIM truncated products
  localparam int ACC_W     = TERM_W + $clog2(DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  // one finished product element
  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } out_elem_t;

  // tags that travel with each multiply-accumulate step
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

endpackage : mm4x4_pkg
`default_nettype wire

@@ design/mm4x4_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4x4 channel interfaces
// Valid/ready channels for loaded elements and for product elements.
// ----------------------------------------------------------------------------
interface mm4x4_in_if import mm4x4_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CELL_W-1:0]        elem_index;
  logic signed [DATA_W-1:0] left_value;
  logic signed [DATA_W-1:0] right_value;
  logic                     load_done;

  modport source (output valid, elem_index, left_value, right_value, load_done,
                  input ready);
  modport sink   (input valid, elem_index, left_value, right_value, load_done,
                  output ready);
endinterface : mm4x4_in_if

interface mm4x4_out_if import mm4x4_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] product_value;
  logic                     out_last;

  modport source (output valid, out_row, out_col, product_value, out_last,
                  input ready);
  modport sink   (input valid, out_row, out_col, product_value, out_last,
                  output ready);
endinterface : mm4x4_out_if
`default_nettype wire

@@ design/mm4x4_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4x4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mm4x4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : mm4x4_ram
`default_nettype wire

@@ design/matrix_multiply_4x4.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// 4x4 signed Q16.16 matrix product with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each input transaction writes one left and one right element at the same
// row-major index, one transaction per cycle. A transaction with load_done
// set is stored and then starts the product: the 16 output elements are
// formed one after another on a single 32x32 multiplier, one term per cycle
// unless output back-pressure holds it. Results leave in row-major order
// through a two-entry output buffer; back-pressure on the output stalls the
// multiplier at an element boundary. The input is not ready while a product
// run is in progress. Products are truncated toward minus infinity by 16
// bits, summed wide and saturated to 32 bits. Entries must be written before
// the first run that reads them.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 import mm4x4_pkg::*; (
  input  wire            clk,
  input  wire            rst_n,
  mm4x4_in_if.sink       in_ch,
  mm4x4_out_if.source    out_ch
);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] i_r, j_r, k_r;
  logic [IDX_W-1:0] i_nxt, j_nxt, k_nxt;
  logic [1:0]       pend_r, pend_nxt;

  logic in_fire, out_fire, issue, start, last_issue;

  logic [CELL_W-1:0]        left_raddr, right_raddr;
  logic signed [DATA_W-1:0] left_rd, right_rd;

  mac_tag_t                 s1_tag_r, s2_tag_r, s1_tag_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_r, acc_sum;
  logic signed [DATA_W-1:0] sat_val;
  logic                     res_wr;

  out_elem_t fifo_q [2];
  out_elem_t res_elem, head;
  logic      wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_ch.load_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_r == 2'd0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      // a new element starts only when an output slot is reserved for it
      ST_RUN:   issue = (k_r != '0) || (pend_r < 2'd2);
      ST_FLUSH: issue = 1'b0;
      default:  issue = 1'b0;
    endcase
  end

  assign start      = issue && (k_r == '0);
  assign last_issue = issue && (i_r == IDX_MAX) && (j_r == IDX_MAX) && (k_r == IDX_MAX);

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (in_fire) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end else if (issue) begin
      k_nxt = k_r + 1'b1;
      if (k_r == IDX_MAX) begin
        k_nxt = '0;
        j_nxt = j_r + 1'b1;
        if (j_r == IDX_MAX) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end
      end
    end
  end

  // elements started and not yet delivered
  assign pend_nxt = pend_r + {1'b0, start} - {1'b0, out_fire};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

  // --------------------------------------------------------------------------
  // element stores
  // --------------------------------------------------------------------------
  assign left_raddr  = {i_r, k_r};
  assign right_raddr = {k_r, j_r};

  mm4x4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_left_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (in_ch.elem_index),
    .wdata (in_ch.left_value),
    .raddr (left_raddr),
    .rdata (left_rd)
  );

  mm4x4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_right_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (in_ch.elem_index),
    .wdata (in_ch.right_value),
    .raddr (right_raddr),
    .rdata (right_rd)
  );

  // --------------------------------------------------------------------------
  // shared multiply-accumulate pipeline
  // --------------------------------------------------------------------------
  always_comb begin
    s1_tag_nxt.vld    = issue;
    s1_tag_nxt.first  = (k_r == '0);
    s1_tag_nxt.last_k = (k_r == IDX_MAX);
    s1_tag_nxt.row    = i_r;
    s1_tag_nxt.col    = j_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
    end else begin
      s1_tag_r <= s1_tag_nxt;
      s2_tag_r <= s1_tag_r;
    end
    prod_r <= PROD_W'(left_rd) * PROD_W'(right_rd);
    if (s2_tag_r.vld) begin
      acc_r <= acc_sum;
    end
  end

  // arithmetic shift keeps the floor of the scaled product
  assign term    = prod_r[PROD_W-1:FRAC_BITS];
  assign acc_sum = (s2_tag_r.first ? ACC_W'(0) : acc_r) + ACC_W'(term);

  always_comb begin
    if (acc_sum > ACC_W'($signed({1'b0, {(DATA_W-1){1'b1}}}))) begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (acc_sum < ACC_W'($signed({1'b1, {(DATA_W-1){1'b0}}}))) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = acc_sum[DATA_W-1:0];
    end
  end

  assign res_wr         = s2_tag_r.vld && s2_tag_r.last_k;
  assign res_elem.row   = s2_tag_r.row;
  assign res_elem.col   = s2_tag_r.col;
  assign res_elem.value = sat_val;
  assign res_elem.last  = (s2_tag_r.row == IDX_MAX) && (s2_tag_r.col == IDX_MAX);

  // --------------------------------------------------------------------------
  // two-entry output buffer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (res_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (out_fire) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, res_wr} - {1'b0, out_fire};
    end
    if (res_wr) begin
      fifo_q[wr_ptr_r] <= res_elem;
    end
  end

  assign head                 = fifo_q[rd_ptr_r];
  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.out_row       = head.row;
  assign out_ch.out_col       = head.col;
  assign out_ch.product_value = head.value;
  assign out_ch.out_last      = head.last;

`ifndef NO_ASSERTIONS
  // the reservation must keep the output buffer from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> (cnt_r != 2'd2) || out_fire)
    else $error("output buffer written while full");

  // loads are taken only with the multiplier drained and nothing pending
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (pend_r == 2'd0) && !s1_tag_r.vld && !s2_tag_r.vld)
    else $error("input ready while a run is in flight");

  // the flagged element is the last one owed by the run
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_ch.out_last) |-> (state_r == ST_FLUSH) && (pend_r == 2'd1))
    else $error("final element delivered out of order");

  // a buffered result always corresponds to a started element
  a_pend_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (pend_r >= cnt_r))
    else $error("result without a started element");
`endif

endmodule : matrix_multiply_4x4
`default_nettype wire
